### rtl/core/tcst_pkg.sv
package tcst_pkg;

  localparam int WAIT_COUNT_BITS_DEF = 20;
  localparam int LIMIT_W             = 20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd60000;

  // Bit positions in the TCP flag byte
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_TX      = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTAB       = 4'd4,
    ST_FIN_WAIT_1  = 4'd5,
    ST_FIN_WAIT_2  = 4'd6,
    ST_CLOSE_WAIT  = 4'd7,
    ST_CLOSING     = 4'd8,
    ST_LAST_ACK    = 4'd9,
    ST_2MSL_WAIT   = 4'd10
  } state_t;

  typedef enum logic [1:0] {
    CMD_PACKET  = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       from_client;
    logic [7:0] tcp_flags;
  } in_item_t;

  typedef struct packed {
    logic [3:0] client_side_state;
    logic [3:0] server_side_state;
    logic       state_changed;
    logic       may_clean_up;
  } out_item_t;

  // Per-side control for one processing step
  typedef struct packed {
    logic       en;
    logic       pkt;
    logic       tick;
    logic       restart;
    logic [7:0] flags;
  } side_ctl_t;

  // Packet transition of one side; the server side differs only in
  // LISTEN and SYN-sent.
  function automatic state_t next_state(state_t cur, logic [7:0] flags,
                                        logic server_side);
    logic   fin;
    logic   syn;
    logic   ack;
    state_t nx;
    fin = flags[FLAG_FIN];
    syn = flags[FLAG_SYN];
    ack = flags[FLAG_ACK];
    nx  = cur;
    if (flags[FLAG_RST]) begin
      nx = ST_CLOSED;
    end else begin
      case (cur)
        ST_LISTEN: begin
          if (server_side && syn && !ack) nx = ST_SYN_RCVD;
        end
        ST_SYN_TX: begin
          if (!server_side) begin
            if (syn && ack)  nx = ST_ESTAB;
            else if (syn)    nx = ST_SYN_RCVD;
          end
        end
        ST_SYN_RCVD: begin
          if (ack)      nx = ST_ESTAB;
          else if (fin) nx = ST_CLOSE_WAIT;
        end
        ST_ESTAB: begin
          if (fin) nx = ST_CLOSE_WAIT;
        end
        ST_FIN_WAIT_1: begin
          if (fin && ack) nx = ST_2MSL_WAIT;
          else if (ack)   nx = ST_FIN_WAIT_2;
          else if (fin)   nx = ST_CLOSING;
        end
        ST_FIN_WAIT_2: begin
          if (fin) nx = ST_2MSL_WAIT;
        end
        ST_CLOSING: begin
          if (ack) nx = ST_2MSL_WAIT;
        end
        ST_LAST_ACK: begin
          if (ack) nx = ST_CLOSED;
        end
        default: begin
          nx = cur;
        end
      endcase
    end
    return nx;
  endfunction

endpackage

### rtl/core/tcst_side.sv
module tcst_side #(
  parameter int WAIT_COUNT_BITS = tcst_pkg::WAIT_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         server_side,
  input  tcst_pkg::side_ctl_t          ctl,
  input  logic [tcst_pkg::LIMIT_W-1:0] limit,
  output tcst_pkg::state_t             state_nxt,
  output logic                         changed,
  output logic                         wait_done
);

  localparam int CMP_W = (WAIT_COUNT_BITS > tcst_pkg::LIMIT_W) ?
                         WAIT_COUNT_BITS : tcst_pkg::LIMIT_W;

  tcst_pkg::state_t             state_r;
  tcst_pkg::state_t             init_state;
  tcst_pkg::state_t             pkt_state;
  logic [WAIT_COUNT_BITS-1:0]   cnt_r;
  logic [WAIT_COUNT_BITS-1:0]   cnt_nxt;

  assign init_state = server_side ? tcst_pkg::ST_LISTEN : tcst_pkg::ST_SYN_TX;
  assign pkt_state  = tcst_pkg::next_state(state_r, ctl.flags, server_side);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    changed   = 1'b0;
    if (ctl.pkt) begin
      if (pkt_state != state_r) begin
        changed   = 1'b1;
        state_nxt = pkt_state;
        // restart the dwell count on entry to the closing wait
        if (pkt_state == tcst_pkg::ST_2MSL_WAIT) cnt_nxt = '0;
      end
    end else if (ctl.tick) begin
      if (state_r == tcst_pkg::ST_2MSL_WAIT && cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else if (ctl.restart) begin
      state_nxt = init_state;
      cnt_nxt   = '0;
    end
  end

  assign wait_done = (state_nxt == tcst_pkg::ST_2MSL_WAIT) &&
                     (CMP_W'(cnt_nxt) >= CMP_W'(limit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= init_state;
      cnt_r   <= '0;
    end else if (ctl.en) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/core/tcp_connection_state_tracker.sv
// Flow: an item accepted at one edge is processed at the next edge that
//   the result register is free, which loads its result into that register.
// Throughput: one item per cycle while out_stall is low; the input and result registers both stall.
// Reset (rst_n, synchronous, active low): drop all items, load SYN-sent on the
//   client side and LISTEN on the server side, clear both counts, limit 60000.
module tcp_connection_state_tracker #(
  parameter int WAIT_COUNT_BITS = tcst_pkg::WAIT_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tcst_pkg::in_item_t           in_item,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output tcst_pkg::out_item_t          out_item,
  // closing wait limit register
  input  logic                         cfg_we,
  input  logic [tcst_pkg::LIMIT_W-1:0] cfg_wdata
);

  // Input register: holds one accepted item until it can be processed.
  logic                s1_valid_r;
  tcst_pkg::in_item_t  s1_item_r;
  // Result register
  logic                out_valid_r;
  tcst_pkg::out_item_t out_item_r;
  logic                out_valid_nxt;
  tcst_pkg::out_item_t out_item_nxt;
  // Configuration
  logic [tcst_pkg::LIMIT_W-1:0] limit_r;

  logic                advance;
  logic                accept;
  logic                step;
  logic                is_pkt;
  logic                is_tick;
  logic                is_restart;
  tcst_pkg::side_ctl_t cli_ctl;
  tcst_pkg::side_ctl_t srv_ctl;
  tcst_pkg::state_t    cli_state_nxt;
  tcst_pkg::state_t    srv_state_nxt;
  logic                cli_changed;
  logic                srv_changed;
  logic                cli_wait_done;
  logic                srv_wait_done;

  // The result register frees up when empty or when its item is taken.
  assign advance  = !out_valid_r || !out_stall;
  // Stall the input only when the held item cannot move on this cycle.
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  // Process the held item: the side states update at this same edge, so
  // the next item processed sees the updated states.
  assign step     = s1_valid_r && advance;

  // Decode the command; the unused code leaves everything as is.
  always_comb begin
    is_pkt     = 1'b0;
    is_tick    = 1'b0;
    is_restart = 1'b0;
    case (s1_item_r.cmd)
      tcst_pkg::CMD_PACKET:  is_pkt     = 1'b1;
      tcst_pkg::CMD_TICK:    is_tick    = 1'b1;
      tcst_pkg::CMD_RESTART: is_restart = 1'b1;
      default: begin
        is_pkt = 1'b0;
      end
    endcase
  end

  // A packet from the server moves the client side, and the other way round.
  always_comb begin
    cli_ctl.en      = step;
    cli_ctl.pkt     = is_pkt && !s1_item_r.from_client;
    cli_ctl.tick    = is_tick;
    cli_ctl.restart = is_restart;
    cli_ctl.flags   = s1_item_r.tcp_flags;
    srv_ctl         = cli_ctl;
    srv_ctl.pkt     = is_pkt && s1_item_r.from_client;
  end

  tcst_side #(
    .WAIT_COUNT_BITS (WAIT_COUNT_BITS)
  ) u_client (
    .clk         (clk),
    .rst_n       (rst_n),
    .server_side (1'b0),
    .ctl         (cli_ctl),
    .limit       (limit_r),
    .state_nxt   (cli_state_nxt),
    .changed     (cli_changed),
    .wait_done   (cli_wait_done)
  );

  tcst_side #(
    .WAIT_COUNT_BITS (WAIT_COUNT_BITS)
  ) u_server (
    .clk         (clk),
    .rst_n       (rst_n),
    .server_side (1'b1),
    .ctl         (srv_ctl),
    .limit       (limit_r),
    .state_nxt   (srv_state_nxt),
    .changed     (srv_changed),
    .wait_done   (srv_wait_done)
  );

  // Build the result from the post-step states. Cleanup is allowed when
  // both sides are closed or either side has sat in the closing wait long
  // enough.
  always_comb begin
    out_item_nxt.client_side_state = cli_state_nxt;
    out_item_nxt.server_side_state = srv_state_nxt;
    out_item_nxt.state_changed     = cli_changed || srv_changed;
    out_item_nxt.may_clean_up      =
      ((cli_state_nxt == tcst_pkg::ST_CLOSED) &&
       (srv_state_nxt == tcst_pkg::ST_CLOSED)) ||
      cli_wait_done || srv_wait_done;
  end

  // Hold the result while stalled; a new step replaces it.
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= tcst_pkg::LIMIT_RESET;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A restart always reports the initial states and no change.
  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    step && (s1_item_r.cmd == tcst_pkg::CMD_RESTART) |=>
      (out_item_r.client_side_state == tcst_pkg::ST_SYN_TX) &&
      (out_item_r.server_side_state == tcst_pkg::ST_LISTEN) &&
      !out_item_r.state_changed)
    else $error("restart did not load initial states");

  // Only packets can report a state change.
  a_change_only_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    step && (s1_item_r.cmd != tcst_pkg::CMD_PACKET) |=> !out_item_r.state_changed)
    else $error("state change flagged on a non-packet item");

  // A held item is neither lost nor altered while the result stage is blocked.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost its item");

  // Both sides closed always permits cleanup.
  a_closed_cleanup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r &&
    (out_item_r.client_side_state == tcst_pkg::ST_CLOSED) &&
    (out_item_r.server_side_state == tcst_pkg::ST_CLOSED) |->
      out_item_r.may_clean_up)
    else $error("closed connection not cleanable");

endmodule

### dv/tcst_checker.sv
`timescale 1ns / 1ps

module tcst_checker #(
  parameter int WAIT_COUNT_BITS = tcst_pkg::WAIT_COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  tcst_pkg::in_item_t           in_item,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  tcst_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [tcst_pkg::LIMIT_W-1:0] cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  import tcst_pkg::*;

  state_t                     cli_st;
  state_t                     srv_st;
  logic [WAIT_COUNT_BITS-1:0] cli_ticks;
  logic [WAIT_COUNT_BITS-1:0] srv_ticks;
  logic [LIMIT_W-1:0]         tw_limit;
  out_item_t                  conn_results_q[$];
  out_item_t                  want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Packet transition of one side; only LISTEN and SYN-sent care which side.
  function automatic state_t side_next(state_t cur, logic [7:0] fl, logic is_server);
    logic fin;
    logic syn;
    logic ack;
    fin = fl[FLAG_FIN];
    syn = fl[FLAG_SYN];
    ack = fl[FLAG_ACK];
    if (fl[FLAG_RST]) return ST_CLOSED;
    case (cur)
      ST_LISTEN:     return (is_server && syn && !ack) ? ST_SYN_RCVD : cur;
      ST_SYN_TX:     return is_server ? cur : (syn ? (ack ? ST_ESTAB : ST_SYN_RCVD) : cur);
      ST_SYN_RCVD:   return ack ? ST_ESTAB : (fin ? ST_CLOSE_WAIT : cur);
      ST_ESTAB:      return fin ? ST_CLOSE_WAIT : cur;
      ST_FIN_WAIT_1: return ack ? (fin ? ST_2MSL_WAIT : ST_FIN_WAIT_2)
                                : (fin ? ST_CLOSING : cur);
      ST_FIN_WAIT_2: return fin ? ST_2MSL_WAIT : cur;
      ST_CLOSING:    return ack ? ST_2MSL_WAIT : cur;
      ST_LAST_ACK:   return ack ? ST_CLOSED : cur;
      default:       return cur;
    endcase
  endfunction

  function automatic logic cleanup_ready();
    if (cli_st == ST_CLOSED && srv_st == ST_CLOSED) return 1'b1;
    if (cli_st == ST_2MSL_WAIT && cli_ticks >= tw_limit) return 1'b1;
    if (srv_st == ST_2MSL_WAIT && srv_ticks >= tw_limit) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the tracked connection by one item and return its result.
  function automatic out_item_t track_item(in_item_t it);
    out_item_t r;
    state_t    nx;
    r = '0;
    case (it.cmd)
      CMD_PACKET: begin
        if (it.from_client) begin
          nx = side_next(srv_st, it.tcp_flags, 1'b1);
          if (nx != srv_st) begin
            r.state_changed = 1'b1;
            if (nx == ST_2MSL_WAIT) srv_ticks = '0;
            srv_st = nx;
          end
        end else begin
          nx = side_next(cli_st, it.tcp_flags, 1'b0);
          if (nx != cli_st) begin
            r.state_changed = 1'b1;
            if (nx == ST_2MSL_WAIT) cli_ticks = '0;
            cli_st = nx;
          end
        end
      end
      CMD_TICK: begin
        if (cli_st == ST_2MSL_WAIT && cli_ticks != '1) cli_ticks = cli_ticks + 1'b1;
        if (srv_st == ST_2MSL_WAIT && srv_ticks != '1) srv_ticks = srv_ticks + 1'b1;
      end
      CMD_RESTART: begin
        cli_st    = ST_SYN_TX;
        srv_st    = ST_LISTEN;
        cli_ticks = '0;
        srv_ticks = '0;
      end
      default: begin
      end
    endcase
    r.client_side_state = cli_st;
    r.server_side_state = srv_st;
    r.may_clean_up      = cleanup_ready();
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cli_st    = ST_SYN_TX;
      srv_st    = ST_LISTEN;
      cli_ticks = '0;
      srv_ticks = '0;
      tw_limit  = LIMIT_RESET;
      conn_results_q.delete();
    end else begin
      if (cfg_we) tw_limit = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (conn_results_q.size() == 0) begin
          $error("result item with nothing pending: %p", out_item);
          fail_count++;
        end else begin
          want = conn_results_q.pop_front();
          if (out_item.client_side_state !== want.client_side_state) begin
            $error("client_side_state: expected %0d, got %0d",
                   want.client_side_state, out_item.client_side_state);
            fail_count++;
          end
          if (out_item.server_side_state !== want.server_side_state) begin
            $error("server_side_state: expected %0d, got %0d",
                   want.server_side_state, out_item.server_side_state);
            fail_count++;
          end
          if (out_item.state_changed !== want.state_changed) begin
            $error("state_changed: expected %0d, got %0d",
                   want.state_changed, out_item.state_changed);
            fail_count++;
          end
          if (out_item.may_clean_up !== want.may_clean_up) begin
            $error("may_clean_up: expected %0d, got %0d",
                   want.may_clean_up, out_item.may_clean_up);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) conn_results_q.push_back(track_item(in_item));
    end
    pending = conn_results_q.size();
  end

endmodule

### dv/tb_tcp_connection_state_tracker.sv
`timescale 1ns / 1ps

module tb_tcp_connection_state_tracker;

  import tcst_pkg::*;

  localparam int         WATCHDOG_LIMIT = 2000;
  // margin for the pipe to settle after the last result is taken
  localparam int         SETTLE_CYCLES  = 6;
  localparam int         PHASE_ITEMS    = 300;
  localparam cmd_t       CMD_UNUSED     = cmd_t'(2'd3);
  localparam logic [7:0] F_FIN          = 8'h01 << FLAG_FIN;
  localparam logic [7:0] F_SYN          = 8'h01 << FLAG_SYN;
  localparam logic [7:0] F_RST          = 8'h01 << FLAG_RST;
  localparam logic [7:0] F_ACK          = 8'h01 << FLAG_ACK;
  // flag bits the tracker does not look at
  localparam logic [7:0] F_IGNORED      = ~(F_FIN | F_SYN | F_RST | F_ACK);

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_item;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  int fails;
  int pending;
  int idle_pct    = 0;
  int stall_left  = 0;
  int quiet_count = 0;

  always #1 clk = ~clk;

  tcp_connection_state_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcst_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fails),
    .pending    (pending)
  );

  // Result side back-pressure: stall in bursts of random length, at the rate
  // the current phase allows. A zero rate gives stall-free stretches.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && $urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: abort when no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("tcp_connection_state_tracker test failed");
      $finish;
    end
  end

  function automatic in_item_t mk(cmd_t c, logic fc, logic [7:0] fl);
    in_item_t it;
    it.cmd         = c;
    it.from_client = fc;
    it.tcp_flags   = fl;
    return it;
  endfunction

  // Random item: mostly packets with handshake and teardown flag patterns,
  // noise in the ignored bits, plus ticks, restarts and the unused code.
  function automatic in_item_t rand_item();
    in_item_t   it;
    int         pick;
    logic [7:0] noise;
    noise          = 8'($urandom) & F_IGNORED;
    it.from_client = 1'($urandom);
    it.tcp_flags   = 8'($urandom);
    pick           = $urandom_range(0, 99);
    if (pick < 70) begin
      it.cmd = CMD_PACKET;
      case ($urandom_range(0, 9))
        0, 5:    it.tcp_flags = F_SYN | noise;
        1:       it.tcp_flags = F_SYN | F_ACK | noise;
        2, 6:    it.tcp_flags = F_ACK | noise;
        3:       it.tcp_flags = F_FIN | noise;
        4:       it.tcp_flags = F_FIN | F_ACK | noise;
        7:       it.tcp_flags = it.tcp_flags | F_RST;
        8:       it.tcp_flags = it.tcp_flags;
        default: it.tcp_flags = noise;
      endcase
    end else if (pick < 85) begin
      it.cmd = CMD_TICK;
    end else if (pick < 95) begin
      it.cmd = CMD_RESTART;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // Present one item and hold it until accepted. Valid stays high on return
  // so back-to-back items need no extra edge.
  task automatic send_item(in_item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every pending result, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) send_item(rand_item());
  endtask

  initial begin
    // hold reset, then release it on a falling edge
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full open on both sides, close-wait, RST on each side,
    // both closed, ticks, unused code, restart, no-transition packets.
    idle_pct = 25;
    send_item(mk(CMD_TICK,    1'b0, 8'h00));
    send_item(mk(CMD_PACKET,  1'b0, F_SYN | F_ACK));
    send_item(mk(CMD_PACKET,  1'b1, F_SYN));
    send_item(mk(CMD_PACKET,  1'b1, F_ACK));
    send_item(mk(CMD_PACKET,  1'b0, F_FIN));
    send_item(mk(CMD_PACKET,  1'b1, F_FIN));
    send_item(mk(CMD_PACKET,  1'b0, 8'hFF));
    send_item(mk(CMD_PACKET,  1'b1, F_RST));
    send_item(mk(CMD_TICK,    1'b1, 8'hFF));
    send_item(mk(CMD_UNUSED,  1'b1, 8'hFF));
    send_item(mk(CMD_PACKET,  1'b0, F_SYN));
    send_item(mk(CMD_RESTART, 1'b0, 8'h00));
    send_item(mk(CMD_PACKET,  1'b1, 8'h00));
    send_item(mk(CMD_PACKET,  1'b1, F_SYN | F_ACK));
    send_item(mk(CMD_PACKET,  1'b0, F_SYN | F_IGNORED));
    send_item(mk(CMD_PACKET,  1'b0, F_FIN));
    send_item(mk(CMD_UNUSED,  1'b0, 8'h00));
    send_item(mk(CMD_RESTART, 1'b1, 8'hFF));
    send_item(mk(CMD_PACKET,  1'b0, 8'hFF & ~F_RST));
    send_item(mk(CMD_PACKET,  1'b1, 8'hFF));
    send_item(mk(CMD_PACKET,  1'b0, 8'h00));
    send_item(mk(CMD_RESTART, 1'b0, 8'h00));

    // Random phases under a range of limits; the sender pauses for a
    // full drain before every register write.
    drain();
    write_limit('0);
    idle_pct = 30;
    run_random(PHASE_ITEMS);

    drain();
    write_limit(20'd1);
    idle_pct = 0;
    run_random(PHASE_ITEMS);

    drain();
    write_limit('1);
    idle_pct = 40;
    run_random(PHASE_ITEMS);

    drain();
    write_limit(LIMIT_W'($urandom_range(2, 20'hFFFFE)));
    idle_pct = 20;
    run_random(PHASE_ITEMS);

    // last stretch runs at full rate on both sides
    drain();
    write_limit(LIMIT_RESET);
    idle_pct = 0;
    run_random(PHASE_ITEMS);

    drain();
    if (fails == 0) begin
      $display("tcp_connection_state_tracker test passed");
    end else begin
      $display("tcp_connection_state_tracker test failed");
    end
    $finish;
  end

endmodule

### tcp_connection_state_tracker.f
rtl/core/tcst_pkg.sv
rtl/core/tcst_side.sv
rtl/core/tcp_connection_state_tracker.sv
dv/tcst_checker.sv
dv/tb_tcp_connection_state_tracker.sv
